// ===== rtl/core/rgb_led_animation_engine_macros.svh =====
// ----------------------------------------------------------------------------
// RGB LED animation engine - assertion macros
// Shared concurrent assertion shorthands, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef RGB_LED_ANIMATION_ENGINE_MACROS_SVH
`define RGB_LED_ANIMATION_ENGINE_MACROS_SVH

// cond must hold at every clock edge outside reset
`define RGBLA_ASSERT_HOLDS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// ante at one edge implies cons at the next edge
`define RGBLA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/rgbla_pkg.sv =====
// ----------------------------------------------------------------------------
// rgbla_pkg
// Types, codes and constant tables of the RGB LED animation engine.
// ----------------------------------------------------------------------------
package rgbla_pkg;

    localparam int STEP_WIDTH_DEF = 8;
    localparam int HUE_W          = 7;
    localparam int PHASE_W        = 4;
    localparam logic [HUE_W-1:0]   HUE_LAST   = 7'd71;
    localparam logic [PHASE_W-1:0] PHASE_LAST = 4'd12;
    localparam logic [7:0]         LEN_RESET  = 8'd80;

    // floor(b*35/100) == (b * 35 * 5243) >> 19 for every 8-bit b
    localparam logic [17:0] GREEN_MUL   = 18'd183505;
    localparam int          GREEN_SHIFT = 19;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_CMD  = 1'b1;

    localparam logic [2:0] CODE_NONE      = 3'd0;
    localparam logic [2:0] CODE_RAINBOW   = 3'd1;
    localparam logic [2:0] CODE_GREEN     = 3'd2;
    localparam logic [2:0] CODE_RED       = 3'd3;
    localparam logic [2:0] CODE_BLUE_BASE = 3'd4;
    localparam logic [2:0] CODE_RBOW_BASE = 3'd5;

    typedef enum logic [1:0] {
        MODE_NONE    = 2'd0,
        MODE_RAINBOW = 2'd1,
        MODE_GREEN   = 2'd2,
        MODE_RED     = 2'd3
    } mode_t;

    typedef struct packed {
        mode_t              mode;
        logic [HUE_W-1:0]   hue;
        logic [PHASE_W-1:0] phase;
        logic [15:0]        gamma;
        logic [7:0]         bright;
        logic [7:0]         green_blue;
        logic               blue_base;
    } color_state_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    typedef logic [15:0] gamma_tab_t [256];

    // largest y in 0..65535 with y^5 * 255^11 <= 2^80 * b^11,
    // i.e. floor(65536 * (b/255)^2.2) capped at 65535
    function automatic logic [15:0] gamma_entry(input int unsigned b);
        logic [175:0] rhs;
        logic [175:0] p255;
        logic [175:0] lhs;
        logic [175:0] bw;
        logic [15:0]  y;
        logic [15:0]  t;
        int           i;
        int           k;
        bw   = 176'(b);
        rhs  = 176'd1;
        p255 = 176'd1;
        for (i = 0; i < 11; i++)
        begin
            rhs  = rhs * bw;
            p255 = p255 * 176'd255;
        end
        rhs = rhs << 80;
        y   = '0;
        for (k = 15; k >= 0; k--)
        begin
            t   = y | (16'd1 << k);
            lhs = 176'(t);
            lhs = lhs * 176'(t) * 176'(t) * 176'(t) * 176'(t) * p255;
            if (lhs <= rhs)
            begin
                y = t;
            end
        end
        return y;
    endfunction

    function automatic gamma_tab_t gamma_build();
        gamma_tab_t tab;
        int         i;
        for (i = 0; i < 256; i++)
        begin
            tab[i] = gamma_entry(i);
        end
        return tab;
    endfunction

    localparam gamma_tab_t GAMMA_TAB = gamma_build();

    // triangle fade over a 13-tick period, saturated at 255
    function automatic logic [7:0] fade_value(input logic [PHASE_W-1:0] p);
        logic [7:0] v;
        unique case (p)
            4'd0, 4'd12: v = 8'd0;
            4'd1, 4'd11: v = 8'd51;
            4'd2, 4'd10: v = 8'd102;
            4'd3, 4'd9:  v = 8'd153;
            4'd4, 4'd8:  v = 8'd204;
            default:     v = 8'd255;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/rgbla_cmd_if.sv =====
// ----------------------------------------------------------------------------
// rgbla_cmd_if
// Command / tick channel: valid-ready handshake with the input item fields.
// ----------------------------------------------------------------------------
interface rgbla_cmd_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [2:0] signal_code;
    logic [7:0] level;

    modport source (output valid, opcode, signal_code, level, input ready);
    modport sink   (input valid, opcode, signal_code, level, output ready);
endinterface

// ===== rtl/core/rgbla_pix_if.sv =====
// ----------------------------------------------------------------------------
// rgbla_pix_if
// RGB result channel: valid-ready handshake with one color triple per beat.
// ----------------------------------------------------------------------------
interface rgbla_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, red, green, blue, input ready);
    modport sink   (input valid, red, green, blue, output ready);
endinterface

// ===== rtl/core/rgb_led_animation_engine.sv =====
// ----------------------------------------------------------------------------
// rgb_led_animation_engine
// Command/tick driven RGB LED animator: base colors and timed animations.
// ----------------------------------------------------------------------------
//  channel   dir  fields                         beat
//  cmd       in   opcode, signal_code, level     one tick or command
//  pix       out  red, green, blue               one color per tick
//  cfg       in   cfg_we, cfg_wdata              animation_length write
//
//  One beat per cycle sustained while pix is ready; a tick passes the input
//  register, then the result register, before its color is on pix.
//  Commands give no output beat; they only update state.
//  A stalled result holds in the result register while the input register
//  still drains commands; ticks wait behind it.
//  Reset: length 80, mode none, blue base at brightness 0.
// ----------------------------------------------------------------------------
`include "rgb_led_animation_engine_macros.svh"

module rgb_led_animation_engine #(
    parameter int STEP_WIDTH = rgbla_pkg::STEP_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    rgbla_cmd_if.sink   cmd,
    rgbla_pix_if.source pix,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata
);
    import rgbla_pkg::*;

    localparam int LIM_W = (STEP_WIDTH > 8) ? STEP_WIDTH : 8;
    localparam logic [LIM_W-1:0] STEP_MAX = LIM_W'((1 << STEP_WIDTH) - 1);

    // input register
    logic       s1_valid_reg;
    logic       s1_opcode_reg;
    logic [2:0] s1_code_reg;
    logic [7:0] s1_level_reg;

    // animation state
    mode_t                  mode_reg;
    logic [STEP_WIDTH-1:0]  step_reg;
    logic [HUE_W-1:0]       hue_reg;
    logic [PHASE_W-1:0]     phase_reg;     // step mod 13, valid while fading
    logic [7:0]             bright_reg;
    logic [7:0]             green_blue_reg; // floor(bright*35/100)
    logic [15:0]            gamma_reg;      // gamma table entry for bright
    logic                   blue_base_reg;
    logic [7:0]             len_reg;

    // result register
    logic       out_valid_reg;
    rgb_t       out_reg;

    logic         s1_tick;
    logic         s1_go;
    logic         out_free;
    color_state_t cst;
    rgb_t         color;
    logic [25:0]  green_prod;
    logic [LIM_W-1:0] limit;
    logic [LIM_W:0]   next_ext;
    logic             step_sat;

    assign s1_tick  = (s1_opcode_reg == OP_TICK);
    assign out_free = !out_valid_reg || pix.ready;
    // commands retire freely; a tick needs room in the result register
    assign s1_go    = s1_valid_reg && (!s1_tick || out_free);
    assign cmd.ready = !s1_valid_reg || s1_go;

    assign pix.valid = out_valid_reg;
    assign pix.red   = out_reg.red;
    assign pix.green = out_reg.green;
    assign pix.blue  = out_reg.blue;

    assign cst.mode       = mode_reg;
    assign cst.hue        = hue_reg;
    assign cst.phase      = phase_reg;
    assign cst.gamma      = gamma_reg;
    assign cst.bright     = bright_reg;
    assign cst.green_blue = green_blue_reg;
    assign cst.blue_base  = blue_base_reg;

    rgbla_color u_color (
        .st    (cst),
        .color (color)
    );

    // blue base green channel, worked out once when the brightness is stored
    assign green_prod = 26'(s1_level_reg) * 26'(GREEN_MUL);

    // step limit: length capped at the largest step value
    always_comb
    begin
        limit    = (LIM_W'(len_reg) > STEP_MAX) ? STEP_MAX : LIM_W'(len_reg);
        next_ext = (LIM_W + 1)'(step_reg) + 1'b1;
        step_sat = (next_ext >= {1'b0, limit});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            s1_valid_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ready && cmd.valid)
        begin
            s1_opcode_reg <= cmd.opcode;
            s1_code_reg   <= cmd.signal_code;
            s1_level_reg  <= cmd.level;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= LEN_RESET;
        end
        else if (cfg_we)
        begin
            len_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_NONE;
            step_reg       <= '0;
            hue_reg        <= '0;
            phase_reg      <= '0;
            bright_reg     <= '0;
            green_blue_reg <= '0;
            gamma_reg      <= '0;
            blue_base_reg  <= 1'b1;
        end
        else if (s1_go)
        begin
            if (!s1_tick)
            begin
                priority if (s1_code_reg == CODE_BLUE_BASE ||
                             s1_code_reg == CODE_RBOW_BASE)
                begin
                    bright_reg     <= s1_level_reg;
                    green_blue_reg <= green_prod[GREEN_SHIFT +: 8];
                    gamma_reg      <= GAMMA_TAB[s1_level_reg];
                    blue_base_reg  <= (s1_code_reg == CODE_BLUE_BASE);
                end
                else if (s1_code_reg == CODE_NONE || s1_code_reg == CODE_RAINBOW ||
                         s1_code_reg == CODE_GREEN || s1_code_reg == CODE_RED)
                begin
                    mode_reg  <= mode_t'(s1_code_reg[1:0]);
                    step_reg  <= '0;
                    hue_reg   <= '0;
                    phase_reg <= '0;
                end
                else
                begin
                    // unused codes: no effect
                    mode_reg <= mode_reg;
                end
            end
            else
            begin
                hue_reg   <= (hue_reg == HUE_LAST) ? '0 : hue_reg + 1'b1;
                phase_reg <= (phase_reg == PHASE_LAST) ? '0 : phase_reg + 1'b1;
                if (step_sat)
                begin
                    step_reg <= limit[STEP_WIDTH-1:0];
                    mode_reg <= MODE_NONE;
                end
                else
                begin
                    step_reg <= next_ext[STEP_WIDTH-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_go && s1_tick)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pix.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && s1_tick)
        begin
            out_reg <= color;
        end
    end

    // ---- checks ----
    `RGBLA_ASSERT_HOLDS(a_hue_range, clk, rst_n, hue_reg <= HUE_LAST, "hue index past wrap")
    `RGBLA_ASSERT_HOLDS(a_phase_range, clk, rst_n, phase_reg <= PHASE_LAST, "fade phase past 12")
    `RGBLA_ASSERT_NEXT(a_tick_result, clk, rst_n, s1_go && s1_tick, out_valid_reg, "tick lost")
    `RGBLA_ASSERT_NEXT(a_cmd_clears, clk, rst_n, s1_go && !s1_tick && s1_code_reg == CODE_GREEN, phase_reg == '0 && step_reg == '0, "fade start not cleared")

endmodule

// ===== rtl/core/rgbla_color.sv =====
// ----------------------------------------------------------------------------
// rgbla_color
// Color of one tick from the current animation state (combinational).
// ----------------------------------------------------------------------------
module rgbla_color (
    input  rgbla_pkg::color_state_t st,
    output rgbla_pkg::rgb_t         color
);
    import rgbla_pkg::*;

    logic [8:0]  h;
    logic [8:0]  d;
    logic [7:0]  ramp;
    logic [7:0]  hr;
    logic [7:0]  hg;
    logic [7:0]  hb;
    logic [23:0] pr;
    logic [23:0] pg;
    logic [23:0] pb;

    // hue in degrees, 5 per index; d is the offset into the 60-degree sector
    always_comb
    begin
        h = 9'(st.hue) * 9'd5;
        hr = 8'd0;
        hg = 8'd0;
        hb = 8'd0;
        priority if (h < 9'd60)
        begin
            d = h;
        end
        else if (h < 9'd120)
        begin
            d = h - 9'd60;
        end
        else if (h < 9'd180)
        begin
            d = h - 9'd120;
        end
        else if (h < 9'd240)
        begin
            d = h - 9'd180;
        end
        else if (h < 9'd300)
        begin
            d = h - 9'd240;
        end
        else
        begin
            d = h - 9'd300;
        end
        ramp = 8'(d << 2);
        priority if (h < 9'd60)
        begin
            hr = 8'd255; hg = ramp;
        end
        else if (h < 9'd120)
        begin
            hr = 8'd255 - ramp; hg = 8'd255;
        end
        else if (h < 9'd180)
        begin
            hg = 8'd255; hb = ramp;
        end
        else if (h < 9'd240)
        begin
            hg = 8'd255 - ramp; hb = 8'd255;
        end
        else if (h < 9'd300)
        begin
            hr = ramp; hb = 8'd255;
        end
        else
        begin
            hr = 8'd255; hb = 8'd255 - ramp;
        end
    end

    // gamma-scaled rainbow, Q0.16 factor, truncated
    assign pr = 24'(hr) * 24'(st.gamma);
    assign pg = 24'(hg) * 24'(st.gamma);
    assign pb = 24'(hb) * 24'(st.gamma);

    always_comb
    begin
        color = '0;
        unique case (st.mode)
            MODE_NONE:
            begin
                if (st.blue_base)
                begin
                    color.green = st.green_blue;
                    color.blue  = st.bright;
                end
                else
                begin
                    color.red   = pr[23:16];
                    color.green = pg[23:16];
                    color.blue  = pb[23:16];
                end
            end
            MODE_RAINBOW:
            begin
                color.red   = hr;
                color.green = hg;
                color.blue  = hb;
            end
            MODE_GREEN: color.green = fade_value(st.phase);
            MODE_RED:   color.red   = fade_value(st.phase);
            default:    color = '0;
        endcase
    end
endmodule
